@@ rtl/core/alk_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package alk_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned VALUE_BITS_DEF     = 32;
  localparam int unsigned MAX_WORD_CHARS_DEF = 6;

  // Fixed field widths of the token channel.
  localparam int unsigned KIND_W  = 5;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned COORD_W = 16;
  localparam logic [COORD_W-1:0] COORD_MAX = '1;

  // Token kinds.
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 5'd0;
  localparam logic [KIND_W-1:0] KIND_INTEGER = 5'd24;

  // Character classes.
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_DIG_LO  = 8'h30;
  localparam logic [7:0] CH_DIG_HI  = 8'h39;
  localparam logic [7:0] CH_UC_LO   = 8'h41;
  localparam logic [7:0] CH_UC_HI   = 8'h5A;
  localparam logic [7:0] CH_LC_LO   = 8'h61;
  localparam logic [7:0] CH_LC_HI   = 8'h7A;

  // Token result buffer depth (a power of two, at least two).
  localparam int unsigned TOK_FIFO_DEPTH = 4;

  // Mnemonic table: text padded with spaces, first character in the top byte.
  localparam int unsigned KW_NUM   = 23;
  localparam int unsigned KW_CHARS = 6;

  localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_NUM] = '{
    "nop   ", "push  ", "pop   ", "dup   ", "indup ", "swap  ", "inswap",
    "add   ", "sub   ", "mul   ", "div   ", "mod   ", "cmpe  ", "cmpne ",
    "cmpg  ", "cmpl  ", "cmpge ", "cmple ", "jmp   ", "zjmp  ", "nzjmp ",
    "print ", "halt  "
  };

  localparam logic [2:0] KW_LEN [KW_NUM] = '{
    3'd3, 3'd4, 3'd3, 3'd3, 3'd5, 3'd4, 3'd6,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd5,
    3'd4, 3'd4, 3'd5, 3'd5, 3'd3, 3'd4, 3'd5,
    3'd5, 3'd4
  };

  // Scanner state, one-hot.
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_WORD   = 3'b010,
    MODE_NUMBER = 3'b100
  } scan_mode_e;

  // One token as it leaves the block.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [OUT_W-1:0]   value;
    logic               overflow;
    logic [COORD_W-1:0] line;
    logic [COORD_W-1:0] column;
    logic               last;
  } tok_t;

  // Up to two tokens handed from the scanner to the result buffer per cycle.
  typedef struct packed {
    logic vld_a;
    logic vld_b;
    tok_t a;
    tok_t b;
  } tok_push_t;

endpackage

`default_nettype wire

@@ rtl/core/alk_char_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Character request channel.
interface alk_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

`default_nettype wire

@@ rtl/core/alk_tok_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Token request channel.
interface alk_tok_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [31:0] int_value;
  logic        int_overflow;
  logic [15:0] token_line;
  logic [15:0] token_column;
  logic        last_of_run;

  modport source (output valid, output token_kind, output int_value, output int_overflow,
                  output token_line, output token_column, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input int_value, input int_overflow,
                  input token_line, input token_column, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/assembly_keyword_number_lexer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake        Payload
// char_i   in   valid / ready    char_code[7:0], end_of_input
// tok_o    out  valid / ready    token_kind[4:0], int_value[31:0], int_overflow,
//                                token_line[15:0], token_column[15:0], last_of_run
//
// One character is taken every cycle while the buffer has room; it waits in the
// input register. The scanner closes up to two tokens per character into a
// four-entry result buffer, so a token is offered once its closing character has
// left the input register and been written into the buffer.
// Input is held off only while the input register is full and the buffer has
// fewer than two free entries.
// Reset is asynchronous and active low; it empties the buffer and sets line and
// column to one. No clearing pass is needed after reset.

module assembly_keyword_number_lexer
  import alk_pkg::*;
#(
  parameter int unsigned VALUE_BITS     = VALUE_BITS_DEF,
  parameter int unsigned MAX_WORD_CHARS = MAX_WORD_CHARS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  alk_char_if.sink  char_i,
  alk_tok_if.source tok_o
);

  tok_push_t push;
  logic      room;

  alk_scan #(
    .VALUE_BITS     (VALUE_BITS),
    .MAX_WORD_CHARS (MAX_WORD_CHARS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_i),
    .room_i (room),
    .push_o (push)
  );

  alk_tok_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .tok_o  (tok_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/alk_kw_match.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Matches a collected word against the mnemonic table.
module alk_kw_match
  import alk_pkg::*;
#(
  parameter int unsigned MAX_WORD_CHARS = MAX_WORD_CHARS_DEF,
  localparam int unsigned LEN_W = $clog2(MAX_WORD_CHARS + 1)
) (
  input  wire logic [7:0]        chars_i [KW_CHARS],
  input  wire logic [LEN_W-1:0]  len_i,
  input  wire logic              too_long_i,
  output logic      [KIND_W-1:0] kind_o
);

  // Each mnemonic is compared in parallel; only its own length is checked.
  always_comb begin
    logic hit;
    kind_o = KIND_UNKNOWN;
    for (int k = 0; k < KW_NUM; k++) begin
      hit = (len_i == LEN_W'(KW_LEN[k]));
      for (int i = 0; i < KW_CHARS; i++) begin
        if ((3'(i) < KW_LEN[k]) &&
            (chars_i[i] != KW_TEXT[k][8*(KW_CHARS-1-i) +: 8])) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        kind_o = KIND_W'(k + 1);
      end
    end
    if (too_long_i) begin
      kind_o = KIND_UNKNOWN;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/alk_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Input register and scanner: classifies one character per cycle while room_i is high and builds tokens.
module alk_scan
  import alk_pkg::*;
#(
  parameter int unsigned VALUE_BITS     = VALUE_BITS_DEF,
  parameter int unsigned MAX_WORD_CHARS = MAX_WORD_CHARS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  alk_char_if.sink   char_i,
  input  wire logic  room_i,
  output tok_push_t  push_o
);

  localparam int unsigned LEN_W  = $clog2(MAX_WORD_CHARS + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_WORD_CHARS);
  localparam int unsigned PROD_W = VALUE_BITS + 4;

  // Input register.
  logic       vld_q;
  logic [7:0] c_q;
  logic       eoi_q;
  logic       fire;

  // Scanner state.
  scan_mode_e             mode_q, mode_d;
  logic [7:0]             words_q [MAX_WORD_CHARS];
  logic [7:0]             words_d [MAX_WORD_CHARS];
  logic [LEN_W-1:0]       len_q, len_d;
  logic                   tl_q, tl_d;
  logic [VALUE_BITS-1:0]  acc_q, acc_d;
  logic                   ovf_q, ovf_d;
  logic [COORD_W-1:0]     line_q, line_d;
  logic [COORD_W-1:0]     col_q, col_d;
  logic [COORD_W-1:0]     sl_q, sl_d;
  logic [COORD_W-1:0]     sc_q, sc_d;

  logic              letter, digit;
  logic              flush1, flush2;
  logic [PROD_W-1:0] prod;
  logic [KIND_W-1:0] kind_old, kind_new;
  tok_t              tok1, tok2;

  assign fire         = vld_q && room_i;
  assign char_i.ready = !vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (char_i.ready) begin
      vld_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      c_q   <= char_i.char_code;
      eoi_q <= char_i.end_of_input;
    end
  end

  // Character classes.
  assign letter = ((c_q >= CH_UC_LO) && (c_q <= CH_UC_HI)) ||
                  ((c_q >= CH_LC_LO) && (c_q <= CH_LC_HI));
  assign digit  = (c_q >= CH_DIG_LO) && (c_q <= CH_DIG_HI);

  // Next scanner state for the character in the input register.
  always_comb begin
    mode_d  = mode_q;
    words_d = words_q;
    len_d   = len_q;
    tl_d    = tl_q;
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    sl_d    = sl_q;
    sc_d    = sc_q;
    flush1  = 1'b0;
    prod    = '0;

    if (letter) begin
      if (mode_q != MODE_WORD) begin
        flush1 = (mode_q != MODE_IDLE);
        mode_d = MODE_WORD;
        len_d  = '0;
        tl_d   = 1'b0;
        acc_d  = '0;
        ovf_d  = 1'b0;
        sl_d   = line_q;
        sc_d   = col_q;
      end
      if (len_d < LEN_W'(MAX_WORD_CHARS)) begin
        words_d[len_d[IDX_W-1:0]] = c_q;
        len_d = len_d + 1'b1;
      end else begin
        tl_d = 1'b1;
      end
    end else if (digit) begin
      if (mode_q != MODE_NUMBER) begin
        flush1 = (mode_q != MODE_IDLE);
        mode_d = MODE_NUMBER;
        len_d  = '0;
        tl_d   = 1'b0;
        acc_d  = '0;
        ovf_d  = 1'b0;
        sl_d   = line_q;
        sc_d   = col_q;
      end
      // Times ten by shift and add; the top four bits show overflow.
      prod = (PROD_W'(acc_d) << 3) + (PROD_W'(acc_d) << 1) + PROD_W'(c_q - CH_DIG_LO);
      if (ovf_d || (prod[PROD_W-1 -: 4] != 4'd0)) begin
        acc_d = '1;
        ovf_d = 1'b1;
      end else begin
        acc_d = prod[VALUE_BITS-1:0];
      end
    end else begin
      flush1 = (mode_q != MODE_IDLE);
      mode_d = MODE_IDLE;
    end

    // End of input closes whatever is pending after this character.
    flush2 = eoi_q && (mode_d != MODE_IDLE);
    if (eoi_q) begin
      mode_d = MODE_IDLE;
    end
  end

  // Line and column counters, saturating.
  always_comb begin
    line_d = line_q;
    col_d  = col_q;
    if (c_q == CH_NEWLINE) begin
      if (line_q != COORD_MAX) begin
        line_d = line_q + 1'b1;
      end
      col_d = COORD_W'(1);
    end else if (col_q != COORD_MAX) begin
      col_d = col_q + 1'b1;
    end
  end

  // Keyword lookup for the word being closed and for the word left open.
  alk_kw_match #(
    .MAX_WORD_CHARS (MAX_WORD_CHARS)
  ) u_match_old (
    .chars_i    (words_q[0:KW_CHARS-1]),
    .len_i      (len_q),
    .too_long_i (tl_q),
    .kind_o     (kind_old)
  );

  alk_kw_match #(
    .MAX_WORD_CHARS (MAX_WORD_CHARS)
  ) u_match_new (
    .chars_i    (words_d[0:KW_CHARS-1]),
    .len_i      (len_d),
    .too_long_i (tl_d),
    .kind_o     (kind_new)
  );

  // Token closed by this character, built from the state before it.
  always_comb begin
    tok1        = '0;
    tok1.line   = sl_q;
    tok1.column = sc_q;
    tok1.last   = !flush2;
    unique case (mode_q)
      MODE_WORD: begin
        tok1.kind = kind_old;
      end
      MODE_NUMBER: begin
        tok1.kind     = KIND_INTEGER;
        tok1.value    = OUT_W'(acc_q);
        tok1.overflow = ovf_q;
      end
      default: begin
        tok1.kind = KIND_UNKNOWN;
      end
    endcase
  end

  // Token closed by end of input, built from the state after this character.
  always_comb begin
    tok2        = '0;
    tok2.line   = sl_d;
    tok2.column = sc_d;
    tok2.last   = 1'b1;
    if (letter) begin
      tok2.kind = kind_new;
    end else begin
      tok2.kind     = KIND_INTEGER;
      tok2.value    = OUT_W'(acc_d);
      tok2.overflow = ovf_d;
    end
  end

  // Older token first.
  always_comb begin
    push_o.vld_a = fire && (flush1 || flush2);
    push_o.vld_b = fire && flush1 && flush2;
    push_o.a     = flush1 ? tok1 : tok2;
    push_o.b     = tok2;
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      len_q  <= '0;
      tl_q   <= 1'b0;
      acc_q  <= '0;
      ovf_q  <= 1'b0;
      line_q <= COORD_W'(1);
      col_q  <= COORD_W'(1);
      sl_q   <= COORD_W'(1);
      sc_q   <= COORD_W'(1);
    end else if (fire) begin
      mode_q <= mode_d;
      len_q  <= len_d;
      tl_q   <= tl_d;
      acc_q  <= acc_d;
      ovf_q  <= ovf_d;
      line_q <= line_d;
      col_q  <= col_d;
      sl_q   <= sl_d;
      sc_q   <= sc_d;
    end
  end

  // Word characters hold no reset value.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      words_q <= words_d;
    end
  end

  // A second token only comes with end of input, behind a first one.
  a_two_tokens_eoi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.vld_b |-> (push_o.vld_a && eoi_q))
    else $error("second token without end of input");

  // After end of input nothing stays pending.
  a_eoi_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && eoi_q) |=> (mode_q == MODE_IDLE))
    else $error("token pending after end of input");

  // Line counter starts at one and never wraps.
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0)
    else $error("line counter wrapped");

endmodule

`default_nettype wire

@@ rtl/core/alk_tok_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Token result buffer: takes up to two tokens a cycle, gives one a cycle while the sink is ready.
module alk_tok_fifo
  import alk_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire tok_push_t push_i,
  output logic           room_o,
  alk_tok_if.source      tok_o
);

  localparam int unsigned PTR_W = $clog2(TOK_FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(TOK_FIFO_DEPTH + 1);

  tok_t             mem_q [TOK_FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             pop;
  logic [CNT_W-1:0] n_push;
  tok_t             head;

  assign pop    = tok_o.valid && tok_o.ready;
  assign n_push = CNT_W'(push_i.vld_a) + CNT_W'(push_i.vld_b);
  assign room_o = count_q <= CNT_W'(TOK_FIFO_DEPTH - 2);

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
      rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
      count_q  <= count_q + n_push - CNT_W'(pop);
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i.vld_a) begin
      mem_q[wr_ptr_q] <= push_i.a;
    end
    if (push_i.vld_b) begin
      mem_q[wr_ptr_q + 1'b1] <= push_i.b;
    end
  end

  // Head of the buffer drives the channel.
  assign head               = mem_q[rd_ptr_q];
  assign tok_o.valid        = count_q != '0;
  assign tok_o.token_kind   = head.kind;
  assign tok_o.int_value    = head.value;
  assign tok_o.int_overflow = head.overflow;
  assign tok_o.token_line   = head.line;
  assign tok_o.token_column = head.column;
  assign tok_o.last_of_run  = head.last;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TOK_FIFO_DEPTH))
    else $error("token buffer overfilled");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.vld_a |-> (count_q <= CNT_W'(TOK_FIFO_DEPTH - 2)))
    else $error("token pushed without room for two");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((count_q == '0) && push_i.vld_a) |=> tok_o.valid)
    else $error("pushed token not presented");

endmodule

`default_nettype wire
